FILE: hdl/nearest_centroid_line_crossing_defines.svh
// Assertion macros used by the tracker top level.
`ifndef NEAREST_CENTROID_LINE_CROSSING_DEFINES_SVH
`define NEAREST_CENTROID_LINE_CROSSING_DEFINES_SVH
`ifndef SYNTHESIS
`define NCLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NCLC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define NCLC_ASSERT(lbl, prop, msg)
`define NCLC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/nclc_pkg.sv
package nclc_pkg;

  localparam int TRACKS_DEF     = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int LINE_W         = 12;
  localparam int SLOT_W         = 4;
  localparam logic [LINE_W-1:0] LINE_RESET = 12'd384;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_MATCH  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic    load;      // capture the incoming word
    logic    rd_en;     // read one table entry for the scan
    logic    rd_first;  // this read is the newest entry
    logic    ins_wr;    // append captured centroid at idx
    logic    match_wr;  // replace the best entry with captured centroid
    logic    finish;    // load the result registers
    status_e status;
  } nclc_cmd_t;

endpackage

FILE: hdl/nclc_ram.sv
module nclc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/nclc_ctrl.sv
module nclc_ctrl
  import nclc_pkg::*;
#(
  parameter int TRACKS = TRACKS_DEF,
  localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1,
  localparam int CNT_W = $clog2(TRACKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             cmd_i,
  output logic             busy_o,
  output nclc_cmd_t        cmd_o,
  output logic [IDX_W-1:0] idx_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_EMPTY,
    S_SCAN,
    S_DRAIN_A,
    S_DRAIN_B,
    S_UPDATE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             first_q, first_d;
  logic             busy_q;
  logic [CNT_W-1:0] cnt_m1;
  logic             full;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign full   = (count_q == CNT_W'(TRACKS));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    scan_d  = scan_q;
    first_d = first_q;
    cmd_o   = '{default: '0, status: ST_OK};
    idx_o   = scan_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
        if (start_i) begin
          if (cmd_e'(cmd_i) == CMD_INSERT) begin
            state_d = S_INSERT;
          end else if (count_q == '0) begin
            state_d = S_EMPTY;
          end else begin
            scan_d  = cnt_m1[IDX_W-1:0];
            first_d = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_INSERT: begin
        cmd_o.finish = 1'b1;
        idx_o        = count_q[IDX_W-1:0];
        if (full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.ins_wr = 1'b1;
          count_d      = count_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end
      S_EMPTY: begin
        cmd_o.finish = 1'b1;
        cmd_o.status = ST_EMPTY;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        // walk newest to oldest
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = first_q;
        first_d        = 1'b0;
        if (scan_q == '0) begin
          state_d = S_DRAIN_A;
        end else begin
          scan_d = scan_q - IDX_W'(1);
        end
      end
      S_DRAIN_A: state_d = S_DRAIN_B;
      S_DRAIN_B: state_d = S_UPDATE;
      S_UPDATE: begin
        cmd_o.match_wr = 1'b1;
        cmd_o.finish   = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      first_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      first_q <= first_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

FILE: hdl/nclc_dp.sv
module nclc_dp
  import nclc_pkg::*;
#(
  parameter int TRACKS     = TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1,
  localparam int SQ_W   = 2 * COORD_BITS,
  localparam int DIST_W = SQ_W + 1,
  localparam int CMP_W  = (COORD_BITS > LINE_W) ? COORD_BITS : LINE_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nclc_cmd_t             cmd_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic                  cfg_we_i,
  input  logic [LINE_W-1:0]     cfg_data_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic                  entering_o,
  output logic                  leaving_o
);

  logic [LINE_W-1:0]       line_y_q;
  logic [COORD_BITS-1:0]   pos_x_q, pos_y_q;

  logic [2*COORD_BITS-1:0] rd_data;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;

  logic                    p1_valid_q, p1_first_q;
  logic [IDX_W-1:0]        p1_idx_q;
  logic                    p2_valid_q, p2_first_q;
  logic [IDX_W-1:0]        p2_idx_q;
  logic [COORD_BITS-1:0]   p2_y_q;
  logic [SQ_W-1:0]         sq_x_q, sq_y_q;

  logic [DIST_W-1:0]       best_d_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [COORD_BITS-1:0]   best_y_q;

  logic [COORD_BITS-1:0]   rx, ry, dx, dy;
  logic [DIST_W-1:0]       dist_sum;

  logic [CMP_W-1:0]        new_c, old_c, line_c;
  logic                    cross_leave, cross_enter;
  logic [IDX_W-1:0]        slot_idx;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  logic                    done_q;
  status_e                 status_q;
  logic [SLOT_W-1:0]       slot_q;
  logic                    entering_q, leaving_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_y_q <= LINE_RESET;
    end else if (cfg_we_i) begin
      line_y_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
    end
  end

  assign ram_we    = cmd_i.ins_wr | cmd_i.match_wr;
  assign ram_waddr = cmd_i.match_wr ? best_idx_q : idx_i;

  nclc_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(TRACKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({pos_x_q, pos_y_q}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_i),
    .rdata_o(rd_data)
  );

  assign rx = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign ry = rd_data[COORD_BITS-1:0];
  assign dx = (rx >= pos_x_q) ? (rx - pos_x_q) : (pos_x_q - rx);
  assign dy = (ry >= pos_y_q) ? (ry - pos_y_q) : (pos_y_q - ry);
  assign dist_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= cmd_i.rd_en;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_first_q <= cmd_i.rd_first;
    p1_idx_q   <= idx_i;
    p2_first_q <= p1_first_q;
    p2_idx_q   <= p1_idx_q;
    p2_y_q     <= ry;
    sq_x_q     <= dx * dx;
    sq_y_q     <= dy * dy;
    // strict less-than keeps the first entry found on a tie
    if (p2_valid_q && (p2_first_q || (dist_sum < best_d_q))) begin
      best_d_q   <= dist_sum;
      best_idx_q <= p2_idx_q;
      best_y_q   <= p2_y_q;
    end
  end

  assign new_c       = CMP_W'(pos_y_q);
  assign old_c       = CMP_W'(best_y_q);
  assign line_c      = CMP_W'(line_y_q);
  assign cross_leave = (new_c <= line_c) && (old_c >= line_c);
  assign cross_enter = !cross_leave && (new_c >= line_c) && (old_c <= line_c);

  always_comb begin
    slot_idx = '0;
    if (cmd_i.match_wr) begin
      slot_idx = best_idx_q;
    end else if (cmd_i.ins_wr) begin
      slot_idx = idx_i;
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q   <= cmd_i.status;
      slot_q     <= slot_ext[SLOT_W-1:0];
      entering_q <= cmd_i.match_wr & cross_enter;
      leaving_q  <= cmd_i.match_wr & cross_leave;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign slot_o     = slot_q;
  assign entering_o = entering_q;
  assign leaving_o  = leaving_q;

endmodule

FILE: hdl/nearest_centroid_line_crossing.sv
// Nearest-centroid tracker with a counting line.
// Input word: pulse start_i with cmd_i, pos_x_i, pos_y_i while busy_o is low;
// the word is taken at that clock edge. cmd_i low appends a track, high
// matches a detection against the table and replaces the nearest track.
// Result word: done_o is high for exactly one cycle with status_o, slot_o,
// entering_o and leaving_o; the receiver cannot hold it off.
// An insert, or a match on an empty table, goes through the S_INSERT or S_EMPTY
// state and then the result registers. A match reads the N stored tracks one
// table read per cycle for the scan, newest first; the distance pipeline
// registers the read, then the squares, then the sum and compare, and the
// nearest track is written back. The table memory has a single read port,
// which sets the scan to one entry per cycle.
// busy_o drops in the cycle the result is shown, so a new word may be taken
// at the same edge as that result.
// Line register: cfg_we_i writes cfg_data_i at a clock edge; the user must write
// it only while idle, as the block itself does not enforce this. Reset empties
// the table (the stored centroids are not cleared) and sets the counting line to 384.
`include "nearest_centroid_line_crossing_defines.svh"

module nearest_centroid_line_crossing
  import nclc_pkg::*;
#(
  parameter int TRACKS     = TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cmd_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic                  cfg_we_i,
  input  logic [LINE_W-1:0]     cfg_data_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic                  entering_o,
  output logic                  leaving_o
);

  nclc_cmd_t        cmd;
  logic [IDX_W-1:0] idx;

  nclc_ctrl #(
    .TRACKS(TRACKS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .idx_o  (idx)
  );

  nclc_dp #(
    .TRACKS    (TRACKS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .idx_i     (idx),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .slot_o    (slot_o),
    .entering_o(entering_o),
    .leaving_o (leaving_o)
  );

  `NCLC_ASSERT(a_done_idle, done_o |-> !busy_o, "result shown while controller busy")
  `NCLC_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o, "accepted word did not raise busy")
  `NCLC_ASSERT(a_error_flags, done_o && (status_o != ST_OK) |-> !entering_o && !leaving_o, "crossing flag on error result")
  `NCLC_ASSERT_NEVER(a_both_flags, done_o && entering_o && leaving_o, "entering and leaving both set")

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nclc_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int CMAX        = (1 << CW) - 1;
  localparam int N_DIR       = 25;
  localparam int N_PHASES    = 6;
  localparam int PHASE_WORDS = 321;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic              entering;
    logic              leaving;
  } outcome_t;

  typedef struct packed {
    cmd_e          cmd;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          typed;
    outcome_t      want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              cmd_i;
  logic [CW-1:0]     pos_x_i;
  logic [CW-1:0]     pos_y_i;
  logic              cfg_we_i;
  logic [LINE_W-1:0] cfg_data_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] slot_o;
  logic              entering_o;
  logic              leaving_o;

  // shadow of the tracker table and counting line
  logic [CW-1:0]     trk_x [TRACKS_DEF];
  logic [CW-1:0]     trk_y [TRACKS_DEF];
  int                trk_n;
  logic [LINE_W-1:0] line_q;

  outcome_t pending_results [$];
  logic     row_typed;
  outcome_t row_want;
  int       words_taken;
  int       n_errors;
  int       n_match, n_enter, n_leave, n_full, n_empty, n_lines;
  int       cycles;

  // directed words: empty match, filling the table, full insert, ties, extremes
  dir_row_t dir_rows [N_DIR] = '{
    '{CMD_MATCH,  12'd100,  12'd200,  1'b1, '{ST_EMPTY, 4'd0,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd0,    12'd0,    1'b1, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd0,    12'd500,  1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd4095, 12'd4095, 1'b1, '{ST_OK,    4'd1,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd4095, 12'd0,    1'b1, '{ST_OK,    4'd2,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd4095, 12'd384,  1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd0,    12'd4095, 1'b1, '{ST_OK,    4'd3,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd2000, 12'd384,  1'b1, '{ST_OK,    4'd4,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd2000, 12'd384,  1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd1000, 12'd1000, 1'b1, '{ST_OK,    4'd5,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd1000, 12'd1000, 1'b1, '{ST_OK,    4'd6,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd3000, 12'd300,  1'b1, '{ST_OK,    4'd7,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd3000, 12'd400,  1'b1, '{ST_OK,    4'd8,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd2047, 12'd2048, 1'b1, '{ST_OK,    4'd9,  1'b0, 1'b0}},
    '{CMD_INSERT, 12'd2048, 12'd2047, 1'b1, '{ST_OK,    4'd10, 1'b0, 1'b0}},
    '{CMD_INSERT, 12'd1365, 12'd2730, 1'b1, '{ST_OK,    4'd11, 1'b0, 1'b0}},
    '{CMD_INSERT, 12'd2730, 12'd1365, 1'b1, '{ST_OK,    4'd12, 1'b0, 1'b0}},
    '{CMD_INSERT, 12'd500,  12'd383,  1'b1, '{ST_OK,    4'd13, 1'b0, 1'b0}},
    '{CMD_INSERT, 12'd600,  12'd385,  1'b1, '{ST_OK,    4'd14, 1'b0, 1'b0}},
    '{CMD_INSERT, 12'd4095, 12'd383,  1'b1, '{ST_OK,    4'd15, 1'b0, 1'b0}},
    '{CMD_INSERT, 12'd5,    12'd5,    1'b1, '{ST_FULL,  4'd0,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd1000, 12'd1000, 1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd3000, 12'd350,  1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd4095, 12'd4095, 1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}},
    '{CMD_MATCH,  12'd0,    12'd0,    1'b0, '{ST_OK,    4'd0,  1'b0, 1'b0}}
  };

  nearest_centroid_line_crossing i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .cmd_i     (cmd_i),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .slot_o    (slot_o),
    .entering_o(entering_o),
    .leaving_o (leaving_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int span2(logic [CW-1:0] ax, logic [CW-1:0] ay,
                               logic [CW-1:0] bx, logic [CW-1:0] by);
    int dx, dy;
    dx = int'(ax) - int'(bx);
    dy = int'(ay) - int'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > CMAX) return CW'(CMAX);
    return CW'(v);
  endfunction

  // Apply one word to the shadow table and return the word it should produce.
  function automatic outcome_t track_step(cmd_e cmd, logic [CW-1:0] px,
                                          logic [CW-1:0] py);
    outcome_t      r;
    int            best, best_d, d;
    logic [CW-1:0] old_y;
    r = '{ST_OK, '0, 1'b0, 1'b0};
    if (cmd == CMD_INSERT) begin
      if (trk_n >= TRACKS_DEF) begin
        r.status = ST_FULL;
      end else begin
        trk_x[trk_n] = px;
        trk_y[trk_n] = py;
        r.slot = SLOT_W'(trk_n);
        trk_n++;
      end
    end else if (trk_n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // scan newest first; strict compare keeps the first one found on a tie
      best = trk_n - 1;
      best_d = span2(trk_x[best], trk_y[best], px, py);
      for (int i = trk_n - 2; i >= 0; i--) begin
        d = span2(trk_x[i], trk_y[i], px, py);
        if (d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      old_y = trk_y[best];
      if (py <= line_q && old_y >= line_q) r.leaving = 1'b1;
      else if (py >= line_q && old_y <= line_q) r.entering = 1'b1;
      trk_x[best] = px;
      trk_y[best] = py;
      r.slot = SLOT_W'(best);
    end
    return r;
  endfunction

  task automatic log_error(input string msg);
    n_errors++;
    if (n_errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Check result words, track the line register, predict each accepted word.
  always @(posedge clk_i) begin
    outcome_t want, got;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          log_error("result word with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            log_error($sformatf("status %0d, want %0d", status_o, want.status));
          if (slot_o !== want.slot)
            log_error($sformatf("slot %0d, want %0d", slot_o, want.slot));
          if (entering_o !== want.entering)
            log_error($sformatf("entering %b, want %b", entering_o, want.entering));
          if (leaving_o !== want.leaving)
            log_error($sformatf("leaving %b, want %b", leaving_o, want.leaving));
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_EMPTY) n_empty++;
          n_enter += want.entering;
          n_leave += want.leaving;
        end
      end
      if (cfg_we_i) line_q = cfg_data_i;
      if (start_i && !busy_o) begin
        got = track_step(cmd_e'(cmd_i), pos_x_i, pos_y_i);
        if (cmd_e'(cmd_i) == CMD_MATCH) n_match++;
        pending_results.push_back(row_typed ? row_want : got);
        words_taken++;
      end
    end
  end

  // Hold start high until the word is taken; returns at a falling edge.
  task automatic send_word(input cmd_e c, input logic [CW-1:0] x,
                           input logic [CW-1:0] y, input logic typed,
                           input outcome_t want);
    int taken;
    taken = words_taken;
    cmd_i = c;
    pos_x_i = x;
    pos_y_i = y;
    row_typed = typed;
    row_want = want;
    start_i = 1'b1;
    do @(negedge clk_i); while (words_taken == taken);
  endtask

  task automatic idle(input int n);
    start_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic set_line(input logic [LINE_W-1:0] v);
    start_i = 1'b0;
    while (pending_results.size() != 0 || busy_o) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    n_lines++;
  endtask

  // Mostly detections near stored tracks and near the line, so crossings and
  // near ties are common; some full-range noise and rejected inserts.
  task automatic pick_word(output cmd_e c, output logic [CW-1:0] x,
                           output logic [CW-1:0] y);
    int roll, a, b;
    roll = $urandom_range(0, 99);
    a = $urandom_range(0, TRACKS_DEF - 1);
    b = $urandom_range(0, TRACKS_DEF - 1);
    c = CMD_MATCH;
    if (roll < 8 || trk_n == 0) begin
      c = (roll < 8) ? CMD_INSERT : CMD_MATCH;
      x = CW'($urandom_range(0, CMAX));
      y = CW'($urandom_range(0, CMAX));
    end else begin
      a = a % trk_n;
      b = b % trk_n;
      if (roll < 23) begin
        x = CW'($urandom_range(0, CMAX));
        y = CW'($urandom_range(0, CMAX));
      end else if (roll < 33) begin
        // midpoint of two tracks: equidistant when the sums are even
        x = CW'((int'(trk_x[a]) + int'(trk_x[b])) / 2);
        y = CW'((int'(trk_y[a]) + int'(trk_y[b])) / 2);
      end else begin
        x = clamp_coord(int'(trk_x[a]) + int'($urandom_range(0, 6)) - 3);
        y = clamp_coord(int'(line_q) + int'($urandom_range(0, 8)) - 4);
      end
    end
  endtask

  initial begin
    int             line_set [N_PHASES];
    bit             quiet;
    cmd_e           c;
    logic [CW-1:0]  x, y;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    row_typed = 1'b0;
    row_want = '0;
    trk_n = 0;
    line_q = LINE_RESET;
    words_taken = 0;
    n_errors = 0;
    cycles = 0;
    {n_match, n_enter, n_leave, n_full, n_empty, n_lines} = '0;
    foreach (trk_x[i]) begin
      trk_x[i] = '0;
      trk_y[i] = '0;
    end
    line_set = '{4095, 0, 384, $urandom_range(0, 4095), 2048,
                 $urandom_range(0, 4095)};

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed,
                dir_rows[i].want);
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 9));
    end

    quiet = 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      set_line(LINE_W'(line_set[p]));
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
        pick_word(c, x, y);
        send_word(c, x, y, 1'b0, '0);
        // the last phase runs back to back
        if (p < N_PHASES - 1 && !quiet && $urandom_range(0, 3) == 0)
          idle($urandom_range(1, 9));
      end
    end

    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);

    $display("Ran %0d words over %0d line settings: %0d matches, %0d entering, %0d leaving",
             words_taken, n_lines, n_match, n_enter, n_leave);
    $display("Rejected: %0d inserts on a full table, %0d matches on an empty one",
             n_full, n_empty);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
